// ----- hw/rtl/rrrs_pkg.sv -----
// shared widths, limits, register indexes and sequencer states for the ring span block
package rrrs_pkg;

   localparam int unsigned ROW_W      = 12;
   localparam int unsigned SIDE_W     = 13;
   localparam int unsigned LEN_W      = 13;
   localparam int unsigned BORDER_W   = 6;
   localparam int unsigned RADIUS_W   = 7;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 13;

   localparam int unsigned MAX_SIDE_DEFAULT = 4096;
   localparam int unsigned BORDER_CAP       = 32;
   localparam int unsigned RADIUS_CAP       = 64;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_WIDTH     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_HEIGHT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BORDER_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CORNER_RADIUS = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ_D,
      ST_SQ_OUT,
      ST_ROOT_OUT,
      ST_SQ_IN,
      ST_ROOT_IN,
      ST_EMIT
   } state_type;

endpackage

// ----- hw/rtl/rrrs_req_if.sv -----
// request channel: one row index per word
interface rrrs_req_if import rrrs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ROW_W-1:0] row_index;

   modport source (output valid, output row_index, input ready);
   modport sink (input valid, input row_index, output ready);
endinterface

// ----- hw/rtl/rrrs_rsp_if.sv -----
// response channel: one span per word
interface rrrs_rsp_if import rrrs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ROW_W-1:0] span_start;
   logic [LEN_W-1:0] span_length;
   logic             last_span;

   modport source (output valid, output span_start, output span_length, output last_span,
                   input ready);
   modport sink (input valid, input span_start, input span_length, input last_span,
                 output ready);
endinterface

// ----- hw/rtl/rounded_ring_row_spans.sv -----
// rounded border ring: spans covered on one row of the outer box
//
// Program box_width, box_height, border_width and corner_radius through the csr
// port (index, data, write enable) while the block is idle. Each request word
// carries a row index; the block answers with one to three response words, one
// span each, ordered left to right, last_span set on the final one. A row outside
// the ring setup (no border, box too small, row below the box) gives one empty span.
// Corner rows run a 6-step bit search for the outer circle and, when the row cuts
// the inner circle, a second one, both on one shared 8x8 squarer. The sequencer
// handles one row at a time and takes the next request once the last span is in
// the output register, so a new row can start while that word still waits.
// A stalled response channel holds the output register and the span sequencer;
// nothing is dropped. Reset clears the csr registers to zero, empties the output
// and returns the sequencer to idle.
module rounded_ring_row_spans import rrrs_pkg::*; #(
   parameter int unsigned MAX_SIDE = MAX_SIDE_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   rrrs_req_if.sink              req,
   rrrs_rsp_if.source            rsp,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int unsigned SideCap = (MAX_SIDE < 8191) ? MAX_SIDE : 8191;

   logic [SIDE_W-1:0]   box_width_ff, box_height_ff;
   logic [BORDER_W-1:0] border_ff;
   logic [RADIUS_W-1:0] radius_ff;

   state_type         state_ff, state_in;
   logic [ROW_W-1:0]  y_ff, y_in;
   logic [13:0]       d2_ff, d2_in;
   logic [14:0]       v_ff, v_in;
   logic [5:0]        m_ff, m_in;
   logic [2:0]        bit_ff, bit_in;
   logic [6:0]        x0_ff, x0_in, x1_ff, x1_in;
   logic [1:0]        idx_ff, idx_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]  rsp_start_ff, rsp_start_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;
   logic              rsp_last_ff, rsp_last_in;

   // geometry from the registers
   logic [SIDE_W-1:0]   w, h;
   logic [BORDER_W-1:0] b;
   logic [RADIUS_W-1:0] r_sat, r;
   logic                empty, band, square, corner;
   logic [SIDE_W-1:0]   row_bot;
   logic [5:0]          row;
   logic [7:0]          d_full;
   logic [6:0]          d, ri2, r_minus_b;
   logic                d_lt;

   // shared squarer
   logic [7:0]          sq_op;
   logic [15:0]         sq;
   logic [5:0]          cand;
   logic                fits;
   logic [5:0]          m_fin;

   // span slots
   logic [ROW_W-1:0]    slot_start [3];
   logic [LEN_W-1:0]    slot_len [3];
   logic [2:0]          raw_present, present;
   logic [1:0]          last_idx;
   logic [6:0]          arc_len;
   logic [SIDE_W-1:0]   two_r, arc_right, frame_right;
   logic                out_free;

   always_comb begin
      w = (box_width_ff > SIDE_W'(SideCap)) ? SIDE_W'(SideCap) : box_width_ff;
      h = (box_height_ff > SIDE_W'(SideCap)) ? SIDE_W'(SideCap) : box_height_ff;
      b = (border_ff > BORDER_W'(BORDER_CAP)) ? BORDER_W'(BORDER_CAP) : border_ff;
      r_sat = (radius_ff > RADIUS_W'(RADIUS_CAP)) ? RADIUS_W'(RADIUS_CAP) : radius_ff;
      r = r_sat;
      if ({6'd0, r} > {1'b0, w[SIDE_W-1:1]}) begin
         r = w[RADIUS_W:1];
      end
      if ({6'd0, r} > {1'b0, h[SIDE_W-1:1]}) begin
         r = h[RADIUS_W:1];
      end
      empty = (b == '0) || (w <= {6'd0, b, 1'b0}) || (h <= {6'd0, b, 1'b0})
              || ({1'b0, y_ff} >= h);
      band = ({1'b0, y_ff} < {7'd0, b}) || ({1'b0, y_ff} >= h - {7'd0, b});
      square = r <= {1'b0, b};
      corner = ({1'b0, y_ff} < {6'd0, r}) || ({1'b0, y_ff} >= h - {6'd0, r});
      row_bot = h - 13'd1 - {1'b0, y_ff};
      row = ({1'b0, y_ff} < {6'd0, r}) ? y_ff[5:0] : row_bot[5:0];
      // doubled distance from the row centre to the circle centre
      d_full = {r, 1'b0} - {1'b0, row, 1'b0} - 8'd1;
      d = d_full[6:0];
      r_minus_b = r - {1'b0, b};
      ri2 = {r_minus_b[5:0], 1'b0};
      d_lt = d < ri2;
   end

   assign cand = m_ff | (6'd1 << bit_ff);

   always_comb begin
      unique case (state_ff)
         ST_SQ_D:     sq_op = {1'b0, d};
         ST_SQ_OUT:   sq_op = {r, 1'b0};
         ST_SQ_IN:    sq_op = {1'b0, ri2};
         default:     sq_op = {1'b0, cand, 1'b0};
      endcase
   end

   assign sq    = sq_op * sq_op;
   assign fits  = sq <= {1'b0, v_ff};
   assign m_fin = fits ? cand : m_ff;

   // span list for the current row, left to right
   always_comb begin
      arc_len     = (x1_ff > x0_ff) ? x1_ff - x0_ff : 7'd0;
      two_r       = {5'd0, r, 1'b0};
      arc_right   = w - {6'd0, x0_ff} - {6'd0, arc_len};
      frame_right = w - {7'd0, b};
      raw_present = 3'b000;
      for (int i = 0; i < 3; i++) begin
         slot_start[i] = '0;
         slot_len[i]   = '0;
      end
      priority if (empty) begin
         raw_present = 3'b000;
      end else if (square && band) begin
         raw_present   = 3'b001;
         slot_len[0]   = w;
      end else if (square || !corner) begin
         raw_present   = 3'b101;
         slot_len[0]   = {7'd0, b};
         slot_start[2] = frame_right[ROW_W-1:0];
         slot_len[2]   = {7'd0, b};
      end else begin
         raw_present[0] = arc_len != '0;
         raw_present[2] = arc_len != '0;
         raw_present[1] = band && (w > two_r);
         slot_start[0]  = {5'd0, x0_ff};
         slot_len[0]    = {6'd0, arc_len};
         slot_start[1]  = {5'd0, r};
         slot_len[1]    = w - two_r;
         slot_start[2]  = arc_right[ROW_W-1:0];
         slot_len[2]    = {6'd0, arc_len};
      end
      present = raw_present;
      if (raw_present == 3'b000) begin
         // nothing covered: one empty span
         present       = 3'b001;
         slot_start[0] = '0;
         slot_len[0]   = '0;
      end
      priority if (present[2]) begin
         last_idx = 2'd2;
      end else if (present[1]) begin
         last_idx = 2'd1;
      end else begin
         last_idx = 2'd0;
      end
   end

   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in     = state_ff;
      y_in         = y_ff;
      d2_in        = d2_ff;
      v_in         = v_ff;
      m_in         = m_ff;
      bit_in       = bit_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_start_in = rsp_start_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               y_in     = req.row_index;
               state_in = ST_SQ_D;
            end
         end
         ST_SQ_D: begin
            d2_in  = sq[13:0];
            idx_in = 2'd0;
            if (empty || square || !corner) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_SQ_OUT;
            end
         end
         ST_SQ_OUT: begin
            // outer bound: largest m with 4m^2 < (2r)^2 - d^2
            v_in     = sq[14:0] - {1'b0, d2_ff} - 15'd1;
            m_in     = '0;
            bit_in   = 3'd5;
            state_in = ST_ROOT_OUT;
         end
         ST_ROOT_OUT: begin
            m_in   = m_fin;
            bit_in = bit_ff - 3'd1;
            if (bit_ff == '0) begin
               x0_in = r - {1'b0, m_fin} - 7'd1;
               if (d_lt) begin
                  state_in = ST_SQ_IN;
               end else begin
                  x1_in    = r;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SQ_IN: begin
            v_in     = sq[14:0] - {1'b0, d2_ff};
            m_in     = '0;
            bit_in   = 3'd5;
            state_in = ST_ROOT_IN;
         end
         ST_ROOT_IN: begin
            m_in   = m_fin;
            bit_in = bit_ff - 3'd1;
            if (bit_ff == '0) begin
               x1_in    = r - {1'b0, m_fin};
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!present[idx_ff]) begin
               idx_in = idx_ff + 2'd1;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_start_in = slot_start[idx_ff];
               rsp_len_in   = slot_len[idx_ff];
               rsp_last_in  = idx_ff == last_idx;
               if (idx_ff == last_idx) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         box_width_ff  <= '0;
         box_height_ff <= '0;
         border_ff     <= '0;
         radius_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_BOX_WIDTH:     box_width_ff  <= csr_write_data;
               CSR_BOX_HEIGHT:    box_height_ff <= csr_write_data;
               CSR_BORDER_WIDTH:  border_ff     <= csr_write_data[BORDER_W-1:0];
               CSR_CORNER_RADIUS: radius_ff     <= csr_write_data[RADIUS_W-1:0];
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      y_ff         <= y_in;
      d2_ff        <= d2_in;
      v_ff         <= v_in;
      m_ff         <= m_in;
      bit_ff       <= bit_in;
      x0_ff        <= x0_in;
      x1_ff        <= x1_in;
      idx_ff       <= idx_in;
      rsp_start_ff <= rsp_start_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req.ready       = state_ff == ST_IDLE;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.span_start  = rsp_start_ff;
   assign rsp.span_length = rsp_len_ff;
   assign rsp.last_span   = rsp_last_ff;

endmodule

// ----- tb/rrrs_span_checker.sv -----
// span checker: predicts the ring spans of every accepted row and compares the response words
`timescale 1ns / 100ps

module rrrs_span_checker import rrrs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   rrrs_req_if                   req,
   rrrs_rsp_if                   rsp,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic                  drain_check,
   output int unsigned           mismatch_count,
   output int unsigned           pending_spans,
   output int unsigned           spans_checked
);

   localparam int unsigned SIDE_LIMIT = MAX_SIDE_DEFAULT;

   typedef struct packed {
      logic [ROW_W-1:0] start;
      logic [LEN_W-1:0] length;
      logic             last;
   } span_word_t;

   logic [SIDE_W-1:0]   cfg_width;
   logic [SIDE_W-1:0]   cfg_height;
   logic [BORDER_W-1:0] cfg_border;
   logic [RADIUS_W-1:0] cfg_radius;
   span_word_t          expected_spans[$];

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] span mismatch: %s", $time, what);
   endtask

   function automatic span_word_t span_word(input int unsigned start, input int unsigned length);
      span_word_t s;
      s.start  = start[ROW_W-1:0];
      s.length = length[LEN_W-1:0];
      s.last   = 1'b0;
      return s;
   endfunction

   // largest m with 4*m*m <= v, or the smallest with 4*m*m >= v when rounding up
   function automatic int unsigned half_root(input int unsigned v, input bit round_up);
      int unsigned m;
      m = 0;
      while (4 * (m + 1) * (m + 1) <= v) m++;
      if (round_up && 4 * m * m < v) m++;
      return m;
   endfunction

   function automatic void predict_row_spans(input logic [ROW_W-1:0] row);
      int unsigned y, w, h, b, r, dbl_dist, inner, x0, x1, len, n, from_rim;
      bit          band;
      span_word_t  spans[3];
      y = row;
      w = (cfg_width > SIDE_LIMIT) ? SIDE_LIMIT : cfg_width;
      h = (cfg_height > SIDE_LIMIT) ? SIDE_LIMIT : cfg_height;
      b = (cfg_border > BORDER_CAP) ? BORDER_CAP : cfg_border;
      r = (cfg_radius > RADIUS_CAP) ? RADIUS_CAP : cfg_radius;
      n = 0;
      if (b != 0 && w > 2 * b && h > 2 * b && y < h) begin
         band = (y < b) || (y >= h - b);
         if (r > w / 2) r = w / 2;
         if (r > h / 2) r = h / 2;
         if (r <= b) begin
            if (band) begin
               spans[n] = span_word(0, w); n++;
            end else begin
               spans[n] = span_word(0, b); n++;
               spans[n] = span_word(w - b, b); n++;
            end
         end else if (y < r || y >= h - r) begin
            from_rim = (y < r) ? y : h - 1 - y;
            // doubled distances keep the row-centre sample on integers
            dbl_dist = 2 * r - 2 * from_rim - 1;
            inner    = 2 * (r - b);
            x0 = r - half_root(4 * r * r - dbl_dist * dbl_dist, 1'b1);
            x1 = r;
            if (dbl_dist < inner) x1 = r - half_root(inner * inner - dbl_dist * dbl_dist, 1'b0);
            len = (x1 > x0) ? x1 - x0 : 0;
            if (len != 0) begin
               spans[n] = span_word(x0, len); n++;
            end
            if (band && w > 2 * r) begin
               spans[n] = span_word(r, w - 2 * r); n++;
            end
            if (len != 0) begin
               spans[n] = span_word(w - x0 - len, len); n++;
            end
         end else begin
            spans[n] = span_word(0, b); n++;
            spans[n] = span_word(w - b, b); n++;
         end
      end
      if (n == 0) begin
         spans[n] = span_word(0, 0); n++;
      end
      spans[n - 1].last = 1'b1;
      for (int i = 0; i < n; i++) expected_spans.insert(expected_spans.size(), spans[i]);
   endfunction

   always @(posedge clock) begin
      span_word_t want;
      if (reset) begin
         cfg_width  = '0;
         cfg_height = '0;
         cfg_border = '0;
         cfg_radius = '0;
         expected_spans.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            spans_checked++;
            if (expected_spans.size() == 0) begin
               report_mismatch($sformatf("unexpected word start %0d length %0d last %0b",
                                         rsp.span_start, rsp.span_length, rsp.last_span));
            end else begin
               want = expected_spans.pop_front();
               if (rsp.span_start !== want.start || rsp.span_length !== want.length ||
                   rsp.last_span !== want.last) begin
                  report_mismatch($sformatf(
                     "got start %0d length %0d last %0b, want start %0d length %0d last %0b",
                     rsp.span_start, rsp.span_length, rsp.last_span,
                     want.start, want.length, want.last));
               end
            end
         end
         if (req.valid && req.ready) predict_row_spans(req.row_index);
         if (csr_write_enable) begin
            case (csr_index)
               CSR_BOX_WIDTH:     cfg_width  = csr_write_data[SIDE_W-1:0];
               CSR_BOX_HEIGHT:    cfg_height = csr_write_data[SIDE_W-1:0];
               CSR_BORDER_WIDTH:  cfg_border = csr_write_data[BORDER_W-1:0];
               CSR_CORNER_RADIUS: cfg_radius = csr_write_data[RADIUS_W-1:0];
               default: ;
            endcase
         end
         if (drain_check && expected_spans.size() != 0) begin
            report_mismatch($sformatf("%0d expected words never came", expected_spans.size()));
            expected_spans.delete();
         end
      end
      pending_spans = expected_spans.size();
   end

endmodule

// ----- tb/tb_rounded_ring_row_spans.sv -----
// testbench top: row stimulus, csr setups, handshake pacing and the verdict
`timescale 1ns / 100ps

module tb_rounded_ring_row_spans;
   import rrrs_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 3000;
   localparam int unsigned SETTLE_CYCLES  = 24;
   localparam int unsigned RANDOM_SETUPS  = 12;
   localparam int unsigned ROWS_PER_SETUP = 25;

   typedef logic [CSR_DATA_W-1:0] csr_word_t;
   typedef enum logic [1:0] {
      PACE_STEADY,
      PACE_SENDER_GAPS,
      PACE_RECEIVER_STALLS,
      PACE_BOTH
   } pace_t;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;
   logic                  drain_check;
   int unsigned           mismatch_count;
   int unsigned           pending_spans;
   int unsigned           spans_checked;
   int unsigned           stuck_cycles;
   int unsigned           rows_sent;
   int unsigned           setups_done;
   int unsigned           eff_height;
   pace_t                 pace;

   rrrs_req_if req_ch ();
   rrrs_rsp_if rsp_ch ();

   rounded_ring_row_spans u_top (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   rrrs_span_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .drain_check      (drain_check),
      .mismatch_count   (mismatch_count),
      .pending_spans    (pending_spans),
      .spans_checked    (spans_checked)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic bit pace_gap(input bit on_sender);
      int unsigned pct;
      case (pace)
         PACE_SENDER_GAPS:     pct = on_sender ? 86 : 0;
         PACE_RECEIVER_STALLS: pct = on_sender ? 0 : 86;
         PACE_BOTH:            pct = 18;
         default:              pct = 0;
      endcase
      return $urandom_range(99) < pct;
   endfunction

   // mostly rows near the top and bottom rims, where the corners live
   function automatic int unsigned pick_row();
      int unsigned sel, rim, row;
      sel = $urandom_range(99);
      if (eff_height == 0 || sel < 12) return $urandom_range(4095);
      if (sel < 27) return $urandom_range(eff_height - 1);
      rim = (eff_height < 80) ? eff_height : 80;
      row = $urandom_range(rim - 1);
      return $urandom_range(1) ? row : eff_height - 1 - row;
   endfunction

   task automatic send_row(input int unsigned row);
      while (pace_gap(1'b1)) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.row_index <= ROW_W'(row);
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      rows_sent++;
   endtask

   // registers change only once every expected word is back and the block has settled
   task automatic setup_box(input csr_word_t w, input csr_word_t h, input csr_word_t b,
                            input csr_word_t r);
      req_ch.valid <= 1'b0;
      while (pending_spans != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_BOX_WIDTH;
      csr_write_data   <= w;
      @(negedge clock);
      csr_index        <= CSR_BOX_HEIGHT;
      csr_write_data   <= h;
      @(negedge clock);
      csr_index        <= CSR_BORDER_WIDTH;
      csr_write_data   <= b;
      @(negedge clock);
      csr_index        <= CSR_CORNER_RADIUS;
      csr_write_data   <= r;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      eff_height = (h > MAX_SIDE_DEFAULT) ? MAX_SIDE_DEFAULT : h;
      setups_done++;
   endtask

   initial begin
      rsp_ch.ready = 1'b1;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= !pace_gap(1'b0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", stuck_cycles);
         $display("tb_rounded_ring_row_spans failed");
         $finish;
      end
   end

   initial begin
      int unsigned w, h, b, r, sel;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.row_index = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_BOX_WIDTH;
      csr_write_data   = '0;
      drain_check      = 1'b0;
      pace             = PACE_STEADY;
      eff_height       = 0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // registers still at reset: no border, so an empty span
      send_row(0);
      // box too narrow, then too short, for the border
      setup_box(8, 100, 4, 0);
      send_row(10);
      setup_box(100, 8, 4, 0);
      send_row(3);
      // radius within the border: square frame
      setup_box(100, 60, 5, 3);
      send_row(0);
      send_row(5);
      send_row(55);
      send_row(60);
      // rounded corners, straight runs in the bands
      setup_box(100, 60, 5, 20);
      send_row(0);
      send_row(4);
      send_row(5);
      send_row(19);
      send_row(20);
      send_row(59);
      send_row(60);
      // radius clipped to half the width, so no straight run
      setup_box(40, 100, 6, 64);
      send_row(0);
      send_row(3);
      send_row(20);
      // every register above its cap
      setup_box(8191, 8191, 63, 127);
      send_row(0);
      send_row(31);
      send_row(63);
      send_row(64);
      send_row(4095);

      for (int phase = 0; phase < RANDOM_SETUPS; phase++) begin
         sel = $urandom_range(9);
         if (sel < 6) begin
            b = $urandom_range(1, 12);
            r = $urandom_range(b + 1, 64);
            w = ($urandom_range(3) == 0) ? 2 * r : $urandom_range(2 * b + 1, 2 * r + 60);
            h = $urandom_range(2 * b + 1, 2 * r + 60);
         end else if (sel < 8) begin
            b = $urandom_range(1, 32);
            r = $urandom_range(b);
            w = $urandom_range(2 * b + 1, 300);
            h = $urandom_range(2 * b + 1, 300);
         end else begin
            b = $urandom_range(63);
            r = $urandom_range(127);
            w = $urandom_range(8191);
            h = ($urandom_range(1) == 0) ? $urandom_range(8191) : $urandom_range(200);
         end
         // stray bits above the narrow registers must be dropped
         if ($urandom_range(1) == 1) begin
            b = b | ($urandom_range(127) << BORDER_W);
            r = r | ($urandom_range(63) << RADIUS_W);
         end
         setup_box(csr_word_t'(w), csr_word_t'(h), csr_word_t'(b), csr_word_t'(r));
         pace = pace_t'(phase % 4);
         for (int k = 0; k < ROWS_PER_SETUP; k++) send_row(pick_row());
      end

      req_ch.valid <= 1'b0;
      while (pending_spans != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      drain_check <= 1'b1;
      @(negedge clock);
      drain_check <= 1'b0;
      @(negedge clock);

      $display("covered %0d rows over %0d box setups, with steady, gappy and stalled handshakes",
               rows_sent, setups_done);
      $display("%0d span words compared against the predicted ring", spans_checked);
      if (mismatch_count == 0) begin
         $display("tb_rounded_ring_row_spans passed");
      end else begin
         $display("tb_rounded_ring_row_spans failed");
      end
      $finish;
   end

endmodule
